/* rtl/gtg_pkg.sv */
package gtg_pkg;

  localparam int COORD_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int ZW      = 28;
  localparam int SQ_IN_W = 18;
  localparam int SQ_W    = 36;
  localparam int SQ_STEPS = 18;

  localparam logic signed [ZW-1:0] PI_Z     = 28'sd52707179;
  localparam logic signed [16:0]   PI_Q12   = 17'sd12868;
  localparam logic signed [16:0]   TURN_Q12 = 17'sd25736;
  localparam logic signed [16:0]   HALF_PI  = 17'sd6433;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_SPEED  = 3'd0,
    REG_STEER_GAIN = 3'd1,
    REG_ARRIVE_RAD = 3'd2,
    REG_ARENA_LOW  = 3'd3,
    REG_ARENA_HIGH = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_CMP,
    ST_RUN,
    ST_ERR,
    ST_MUL,
    ST_OUT
  } state_t;

  function automatic logic signed [ZW-1:0] gtg_atan(input int idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      0:  a = 28'sd13176795;
      1:  a = 28'sd7778716;
      2:  a = 28'sd4110060;
      3:  a = 28'sd2086331;
      4:  a = 28'sd1047214;
      5:  a = 28'sd524117;
      6:  a = 28'sd262123;
      7:  a = 28'sd131069;
      8:  a = 28'sd65536;
      9:  a = 28'sd32768;
      10: a = 28'sd16384;
      11: a = 28'sd8192;
      12: a = 28'sd4096;
      13: a = 28'sd2048;
      14: a = 28'sd1024;
      15: a = 28'sd512;
      16: a = 28'sd256;
      17: a = 28'sd128;
      18: a = 28'sd64;
      19: a = 28'sd32;
      20: a = 28'sd16;
      21: a = 28'sd8;
      22: a = 28'sd4;
      23: a = 28'sd2;
      24: a = 28'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/go_to_goal_steering_top.sv */
// Go-to-goal steering controller. A goal beat (tuser high) stores the target and arms the
// block. A pose beat against an armed goal yields one command beat: an arrival stop, or
// speed and turn rate (speed zeroed with a boundary flag at an arena edge). Speed and
// turn rate wait for the 18-step square-root iteration running beside the chain of
// CORDIC_STEPS bearing cells, whichever finishes later. One pose is worked on at a time; a
// finished command waits in the output register while the next beat is taken in.
module go_to_goal_steering_top
  import gtg_pkg::*;
#(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // coord_x, coord_y, heading, zero fill
  input  logic [((2*COORD_WIDTH+15+7)/8)*8-1:0] s_tdata,
  // operation
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // linear_speed, angular_rate, zero fill
  output logic [31:0]           m_tdata,
  // goal_reached, boundary_stop
  output logic [1:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int FW = (DW > 19) ? DW : 19;
  localparam int XW = CW + 4;
  localparam int EW = ((CW > 16) ? CW : 16) + 1;
  localparam logic signed [FW-1:0] FAR_POS = FW'(131072);
  localparam logic signed [FW-1:0] FAR_NEG = -FAR_POS;
  localparam logic [SQ_W-1:0] SQ_BIT0 = SQ_W'(1) << (2*SQ_STEPS-2);

  state_t state, state_next;

  logic [14:0]        max_speed;
  logic [11:0]        gain;
  logic [14:0]        arrive_rad;
  logic signed [15:0] arena_low;
  logic signed [15:0] arena_high;

  logic signed [CW-1:0] target_x, target_y;
  logic                 armed;
  logic signed [CW-1:0] px, py;
  logic signed [14:0]   hd;
  logic signed [15:0]   hd_wrap;

  logic signed [FW-1:0] dx, dy;
  logic                 far, zero_vec;
  logic [SQ_W-1:0]      sqx, sqy, sq;
  logic [29:0]          rsq;
  logic                 arrive;

  logic [SQ_W-1:0]      sq_rem, sq_root, sq_bit;
  logic [4:0]           sq_cnt;

  logic                 cdc_done, bearing_ok;
  logic [4:0]           cdc_cnt;
  logic signed [ZW-1:0] cdc_angle;
  logic signed [15:0]   bearing;
  logic signed [15:0]   err;
  logic signed [28:0]   prod;

  logic                 cdc_start;
  logic                 cdc_neg;
  logic signed [XW-1:0] cdc_x0, cdc_y0;
  logic signed [ZW-1:0] cdc_z0;

  logic signed [DW-1:0] dx_w, dy_w;
  logic signed [15:0]   hd_ext;
  logic signed [SQ_IN_W-1:0] dxs, dys;
  logic signed [SQ_W-1:0] sqx_full, sqy_full;
  logic [SQ_W-1:0]      sq_try;
  logic signed [ZW-1:0] z_round;
  logic signed [16:0]   diff;
  logic signed [28:0]   rate_full;
  logic signed [15:0]   rate;
  logic [14:0]          lin;
  logic signed [EW-1:0] pxe, pye, lowe, highe;
  logic signed [16:0]   w;
  logic                 cpos, spos, sneg, edge_hit;
  logic                 out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed  <= 15'd2048;
      gain       <= 12'd512;
      arrive_rad <= 15'd102;
      arena_low  <= 16'sd0;
      arena_high <= 16'sd11264;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_SPEED:  max_speed  <= cfg_data[14:0];
        REG_STEER_GAIN: gain       <= cfg_data[11:0];
        REG_ARRIVE_RAD: arrive_rad <= cfg_data[14:0];
        REG_ARENA_LOW:  arena_low  <= $signed(cfg_data);
        REG_ARENA_HIGH: arena_high <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cdc_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = s_tuser ? ST_IDLE : ST_DIFF;
        end
      end
      ST_DIFF: state_next = armed ? ST_SQ : ST_IDLE;
      ST_SQ: begin
        cdc_start  = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_CMP;
      ST_CMP: state_next = (!far && sq < SQ_W'(rsq)) ? ST_OUT : ST_RUN;
      ST_RUN: begin
        if (sq_cnt == '0 && bearing_ok) begin
          state_next = ST_ERR;
        end
      end
      ST_ERR: state_next = ST_MUL;
      ST_MUL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign dx_w     = DW'(target_x) - DW'(px);
  assign dy_w     = DW'(target_y) - DW'(py);
  assign hd_ext   = 16'(hd);
  assign dxs      = SQ_IN_W'(dx);
  assign dys      = SQ_IN_W'(dy);
  assign sqx_full = dxs * dxs;
  assign sqy_full = dys * dys;
  assign sq_try   = sq_root + sq_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b0;
    end else if (state == ST_IDLE && s_tvalid && s_tuser) begin
      armed <= 1'b1;
    end else if (state == ST_CMP && !far && sq < SQ_W'(rsq)) begin
      armed <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
    end else if (state == ST_IDLE && s_tvalid && s_tuser) begin
      target_x <= $signed(s_tdata[CW-1:0]);
      target_y <= $signed(s_tdata[2*CW-1:CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      px <= $signed(s_tdata[CW-1:0]);
      py <= $signed(s_tdata[2*CW-1:CW]);
      hd <= $signed(s_tdata[2*CW+14:2*CW]);
    end
    if (state == ST_DIFF) begin
      dx       <= FW'(dx_w);
      dy       <= FW'(dy_w);
      zero_vec <= (dx_w == '0) && (dy_w == '0);
      far      <= (FW'(dx_w) >= FAR_POS) || (FW'(dx_w) <= FAR_NEG) ||
                  (FW'(dy_w) >= FAR_POS) || (FW'(dy_w) <= FAR_NEG);
      if (hd_ext > 16'(PI_Q12)) begin
        hd_wrap <= hd_ext - 16'(TURN_Q12);
      end else if (hd_ext < -16'(PI_Q12)) begin
        hd_wrap <= hd_ext + 16'(TURN_Q12);
      end else begin
        hd_wrap <= hd_ext;
      end
    end
    if (state == ST_SQ) begin
      sqx <= $unsigned(sqx_full);
      sqy <= $unsigned(sqy_full);
      rsq <= arrive_rad * arrive_rad;
    end
    if (state == ST_SUM) begin
      sq <= sqx + sqy;
    end
    if (state == ST_CMP) begin
      arrive  <= !far && sq < SQ_W'(rsq);
      sq_rem  <= sq;
      sq_root <= '0;
      sq_bit  <= SQ_BIT0;
      sq_cnt  <= 5'(SQ_STEPS);
    end else if (state == ST_IDLE) begin
      arrive <= 1'b0;
    end
    if (state == ST_RUN && sq_cnt != '0) begin
      if (sq_rem >= sq_try) begin
        sq_rem  <= sq_rem - sq_try;
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - 5'd1;
    end
    if (state == ST_ERR) begin
      if (diff > PI_Q12) begin
        err <= 16'(diff - TURN_Q12);
      end else if (diff < -PI_Q12) begin
        err <= 16'(diff + TURN_Q12);
      end else begin
        err <= 16'(diff);
      end
    end
    if (state == ST_MUL) begin
      prod <= $signed({1'b0, gain}) * err;
    end
  end

  // bearing chain
  assign cdc_neg = dx < 0;
  assign cdc_x0  = cdc_neg ? -XW'(dx) : XW'(dx);
  assign cdc_y0  = cdc_neg ? -XW'(dy) : XW'(dy);
  assign cdc_z0  = !cdc_neg ? '0 : ((dy >= 0) ? PI_Z : -PI_Z);

  gtg_cordic #(.XW(XW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cdc_start),
    .x0   (cdc_x0),
    .y0   (cdc_y0),
    .z0   (cdc_z0),
    .done (cdc_done),
    .angle(cdc_angle)
  );

  assign z_round = (cdc_angle + ZW'(2048)) >>> 12;

  // only the beat of the latest start leaves the chain with the count at one
  always_ff @(posedge clk) begin
    if (rst) begin
      bearing_ok <= 1'b0;
      cdc_cnt    <= '0;
    end else if (cdc_start) begin
      bearing_ok <= 1'b0;
      cdc_cnt    <= 5'(CORDIC_STEPS);
    end else begin
      if (cdc_cnt != '0) begin
        cdc_cnt <= cdc_cnt - 5'd1;
      end
      if (cdc_done && cdc_cnt == 5'd1) begin
        bearing_ok <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cdc_done && cdc_cnt == 5'd1) begin
      bearing <= zero_vec ? '0 : 16'(z_round);
    end
  end

  assign diff = 17'(bearing) - 17'(hd_wrap);

  // command assembly
  assign rate_full = (prod + 29'sd512) >>> 10;
  always_comb begin
    if (rate_full > 29'sd32767) begin
      rate = 16'sd32767;
    end else if (rate_full < -29'sd32768) begin
      rate = -16'sd32768;
    end else begin
      rate = 16'(rate_full);
    end
  end

  always_comb begin
    if (far || sq_root > SQ_W'(max_speed)) begin
      lin = max_speed;
    end else begin
      lin = 15'(sq_root);
    end
  end

  assign w     = 17'(hd_wrap);
  assign pxe   = EW'(px);
  assign pye   = EW'(py);
  assign lowe  = EW'(arena_low);
  assign highe = EW'(arena_high);
  assign cpos  = (w <= HALF_PI) && (w >= -HALF_PI);
  assign spos  = (w >= 17'sd1 && w <= PI_Q12 - 17'sd1) || w == -PI_Q12;
  assign sneg  = (w <= -17'sd1 && w >= -(PI_Q12 - 17'sd1)) || w == PI_Q12;
  assign edge_hit = (pxe <= lowe && !cpos) || (pxe >= highe && cpos) ||
                    (pye <= lowe && sneg) || (pye >= highe && spos);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      if (arrive) begin
        m_tdata <= '0;
        m_tuser <= 2'b01;
      end else begin
        m_tdata <= {1'b0, rate, edge_hit ? 15'd0 : lin};
        m_tuser <= {edge_hit, 1'b0};
      end
    end
  end

endmodule

/* rtl/gtg_cell.sv */
module gtg_cell
  import gtg_pkg::*;
#(
  parameter int SHIFT = 0,
  parameter int XW    = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  output logic                 out_valid,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z
);

  localparam logic signed [ZW-1:0] ANGLE = gtg_atan(SHIFT);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_y > 0) begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + ANGLE;
    end else begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - ANGLE;
    end
  end

endmodule

/* rtl/gtg_cordic.sv */
module gtg_cordic
  import gtg_pkg::*;
#(
  parameter int XW    = 20,
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [XW-1:0] x0,
  input  logic signed [XW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [ZW-1:0] angle
);

  logic                 v [STEPS+1];
  logic signed [XW-1:0] x [STEPS+1];
  logic signed [XW-1:0] y [STEPS+1];
  logic signed [ZW-1:0] z [STEPS+1];

  assign v[0] = start;
  assign x[0] = x0;
  assign y[0] = y0;
  assign z[0] = z0;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    gtg_cell #(.SHIFT(i), .XW(XW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[i]),
      .in_x     (x[i]),
      .in_y     (y[i]),
      .in_z     (z[i]),
      .out_valid(v[i+1]),
      .out_x    (x[i+1]),
      .out_y    (y[i+1]),
      .out_z    (z[i+1])
    );
  end

  assign done  = v[STEPS];
  assign angle = z[STEPS];

endmodule

/* rtl/gtg_checker.sv */
module gtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_arrival_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
    else $error("arrival beat carries a command");

  a_edge_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[14:0] == '0)
    else $error("edge stop with forward speed");

  a_pose_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !s_tready)
    else $error("pose beat did not occupy the block");

endmodule

bind go_to_goal_steering_top gtg_checker u_gtg_checker (.*);
